@@ rtl/madc_pkg.sv @@
// Shared definitions for the multiplexed ADC request scheduler.
// Holds opcodes, register indexes, conversion constants and the control store.
// No dependencies.
package madc_pkg;

	localparam int CHANNELS_DEF = 16;
	localparam int ADDR_W       = 4;

	// input opcodes
	localparam logic [1:0] OP_REQ  = 2'd0;
	localparam logic [1:0] OP_DONE = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	// register indexes (byte address / 4)
	localparam logic [1:0] R_MUX     = 2'd0;
	localparam logic [1:0] R_RANGE   = 2'd1;
	localparam logic [1:0] R_SHIFT   = 2'd2;
	localparam logic [1:0] R_TIMEOUT = 2'd3;

	localparam logic        KIND_RESULT = 1'b0;
	localparam logic        KIND_START  = 1'b1;

	localparam logic [2:0]  SHIFT_RST    = 3'd2;
	localparam logic [15:0] TIMEOUT_RST  = 16'd1060;
	localparam logic [15:0] ELAPSED_MAX  = 16'hFFFF;
	localparam logic [9:0]  CODE_SCALE   = 10'd1000;
	localparam logic signed [27:0] VOLT_OFFSET = 28'sd9216000;
	localparam logic signed [27:0] OVERLOAD_UV = 28'sd100000000;
	localparam logic signed [27:0] TRUNC_BIAS  = 28'sd15;

	// datapath actions
	localparam logic [3:0] A_NOP        = 4'd0;
	localparam logic [3:0] A_FETCH      = 4'd1;
	localparam logic [3:0] A_SET_PEND   = 4'd2;
	localparam logic [3:0] A_START_REQ  = 4'd3;
	localparam logic [3:0] A_UNSUP      = 4'd4;
	localparam logic [3:0] A_CLR_TMO    = 4'd5;
	localparam logic [3:0] A_TICK       = 4'd6;
	localparam logic [3:0] A_MUL        = 4'd7;
	localparam logic [3:0] A_SUB        = 4'd8;
	localparam logic [3:0] A_RESULT     = 4'd9;
	localparam logic [3:0] A_SCAN_INIT  = 4'd10;
	localparam logic [3:0] A_SCAN       = 4'd11;
	localparam logic [3:0] A_START_SCAN = 4'd12;

	// jump conditions
	localparam logic [3:0] C_NEXT       = 4'd0;
	localparam logic [3:0] C_ALWAYS     = 4'd1;
	localparam logic [3:0] C_OP_NOT_REQ = 4'd2;
	localparam logic [3:0] C_UNSUP      = 4'd3;
	localparam logic [3:0] C_NO_START   = 4'd4;
	localparam logic [3:0] C_OP3        = 4'd5;
	localparam logic [3:0] C_OP_DONE    = 4'd6;
	localparam logic [3:0] C_NO_TMO     = 4'd7;
	localparam logic [3:0] C_IDLE       = 4'd8;
	localparam logic [3:0] C_NONE_PEND  = 4'd9;
	localparam logic [3:0] C_NOT_HIT    = 4'd10;

	// program steps
	localparam logic [3:0] S_FETCH      = 4'd0;
	localparam logic [3:0] S_DISPATCH   = 4'd1;
	localparam logic [3:0] S_REQ_CHK    = 4'd2;
	localparam logic [3:0] S_REQ_SET    = 4'd3;
	localparam logic [3:0] S_REQ_START  = 4'd4;
	localparam logic [3:0] S_UNSUP      = 4'd5;
	localparam logic [3:0] S_OP3        = 4'd6;
	localparam logic [3:0] S_DONE_CHK   = 4'd7;
	localparam logic [3:0] S_TICK       = 4'd8;
	localparam logic [3:0] S_BUSY_CHK   = 4'd9;
	localparam logic [3:0] S_MUL        = 4'd10;
	localparam logic [3:0] S_SUB        = 4'd11;
	localparam logic [3:0] S_RESULT     = 4'd12;
	localparam logic [3:0] S_SCAN_INIT  = 4'd13;
	localparam logic [3:0] S_SCAN       = 4'd14;
	localparam logic [3:0] S_SCAN_START = 4'd15;

	typedef struct packed {
		logic [3:0] act;
		logic [3:0] cond;
		logic [3:0] target;
		logic       emit;
	} ctrl_t;

	function automatic ctrl_t ucode(input logic [3:0] pc);
		ctrl_t w;
		w = '{act: A_NOP, cond: C_ALWAYS, target: S_FETCH, emit: 1'b0};
		unique case (pc)
			S_FETCH:      w = '{act: A_FETCH,      cond: C_NEXT,       target: S_FETCH,    emit: 1'b0};
			S_DISPATCH:   w = '{act: A_NOP,        cond: C_OP_NOT_REQ, target: S_OP3,      emit: 1'b0};
			S_REQ_CHK:    w = '{act: A_NOP,        cond: C_UNSUP,      target: S_UNSUP,    emit: 1'b0};
			S_REQ_SET:    w = '{act: A_SET_PEND,   cond: C_NO_START,   target: S_FETCH,    emit: 1'b0};
			S_REQ_START:  w = '{act: A_START_REQ,  cond: C_ALWAYS,     target: S_FETCH,    emit: 1'b1};
			S_UNSUP:      w = '{act: A_UNSUP,      cond: C_ALWAYS,     target: S_FETCH,    emit: 1'b1};
			S_OP3:        w = '{act: A_NOP,        cond: C_OP3,        target: S_FETCH,    emit: 1'b0};
			S_DONE_CHK:   w = '{act: A_CLR_TMO,    cond: C_OP_DONE,    target: S_BUSY_CHK, emit: 1'b0};
			S_TICK:       w = '{act: A_TICK,       cond: C_NO_TMO,     target: S_FETCH,    emit: 1'b0};
			S_BUSY_CHK:   w = '{act: A_NOP,        cond: C_IDLE,       target: S_FETCH,    emit: 1'b0};
			S_MUL:        w = '{act: A_MUL,        cond: C_NEXT,       target: S_FETCH,    emit: 1'b0};
			S_SUB:        w = '{act: A_SUB,        cond: C_NEXT,       target: S_FETCH,    emit: 1'b0};
			S_RESULT:     w = '{act: A_RESULT,     cond: C_NEXT,       target: S_FETCH,    emit: 1'b1};
			S_SCAN_INIT:  w = '{act: A_SCAN_INIT,  cond: C_NONE_PEND,  target: S_FETCH,    emit: 1'b0};
			S_SCAN:       w = '{act: A_SCAN,       cond: C_NOT_HIT,    target: S_SCAN,     emit: 1'b0};
			S_SCAN_START: w = '{act: A_START_SCAN, cond: C_ALWAYS,     target: S_FETCH,    emit: 1'b1};
			default:      w = '{act: A_NOP,        cond: C_ALWAYS,     target: S_FETCH,    emit: 1'b0};
		endcase
		return w;
	endfunction

endpackage

@@ rtl/madc_if.sv @@
// Valid/ready channels of the ADC request scheduler: request items in,
// result and start-command beats out. No dependencies.
interface madc_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [7:0]  channel;
	logic [15:0] adc_code;

	modport source (output valid, opcode, channel, adc_code, input ready);
	modport sink   (input valid, opcode, channel, adc_code, output ready);
endinterface

interface madc_result_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [7:0]         chan_out;
	logic signed [27:0] volts_value;
	logic               overload;
	logic               timed_out;
	logic               unsupported;
	logic [3:0]         control_word;
	logic               last;

	modport source (output valid, kind, chan_out, volts_value, overload, timed_out,
		unsupported, control_word, last, input ready);
	modport sink   (input valid, kind, chan_out, volts_value, overload, timed_out,
		unsupported, control_word, last, output ready);
endinterface

@@ rtl/muxed_adc_request_scheduler.sv @@
// Top level of the multiplexed ADC request scheduler: microcoded sequencer,
// pending-bit store, conversion datapath and APB register block.
// Depends on madc_pkg and the channels in madc_if.sv.
//
// Usage: items (opcode, channel, adc_code) enter on the items channel; each
// causes zero, one or two beats on the results channel, the last one flagged
// by last. A request marks a channel pending and, when no conversion runs,
// issues a start command (kind 1). A done event, or a millisecond tick past
// timeout_ms, emits the measurement (kind 0) and then starts the next pending
// channel found round-robin. Registers are written over the APB port at byte
// address 4*index; the user must write them only while no item is in flight,
// as the block itself does not enforce it.
// Program steps: a request passes dispatch, the support check and the pending
// update, plus a start step if it starts a conversion; a done or a timeout of
// a running conversion passes the multiply, subtract and result steps, then,
// when another channel waits, a round-robin scan and a start-command step.
// Results sit in one output register; the next beat may load in the cycle the
// current one is taken. While the receiver stalls, the sequencer holds on its
// emitting step and no new item is accepted.
// Reset clears the pending bits, the sequencer and the registers to their
// defaults (timeout 1060 ms, integration code 2); the block is usable at once.
module muxed_adc_request_scheduler #(
	parameter int CHANNELS = madc_pkg::CHANNELS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	madc_item_if.sink                   items,
	madc_result_if.source               results,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [madc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import madc_pkg::*;

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W = $clog2(CHANNELS + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

	// configuration
	logic        mux_q;
	logic        range_q;
	logic [2:0]  shift_q;
	logic [15:0] timeout_q;

	// scheduler state
	logic [3:0]          pc_q;
	logic [CHANNELS-1:0] pend_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic [7:0]          cur_q;
	logic [15:0]         elapsed_q;
	logic [IDX_W-1:0]    x_q;
	logic                tmo_q;

	// latched item
	logic [1:0]  op_q;
	logic [7:0]  ch_q;
	logic [15:0] code_q;

	// conversion datapath
	logic [25:0]        prod_q;
	logic signed [27:0] diff_q;

	// output register
	logic               ov_q;
	logic               o_kind_q;
	logic [7:0]         o_chan_q;
	logic signed [27:0] o_volts_q;
	logic               o_ovl_q;
	logic               o_tmo_q;
	logic               o_uns_q;
	logic [3:0]         o_cw_q;
	logic               o_last_q;

	ctrl_t              cw;
	logic               out_free;
	logic               stall;
	logic               go;
	logic               jump;
	logic               unsup;
	logic [IDX_W-1:0]   rd_idx;
	logic               pend_rd;
	logic [15:0]        elapsed_inc;
	logic [IDX_W-1:0]   cur_idx;
	logic [IDX_W-1:0]   cur_next;
	logic [IDX_W-1:0]   x_next;
	logic signed [27:0] div_val;
	logic signed [27:0] meas_val;
	logic [25:0]        scaled;
	logic               cfg_wr;

	assign cw       = ucode(pc_q);
	assign out_free = !ov_q || results.ready;
	assign stall    = ((cw.act == A_FETCH) && !items.valid) || (cw.emit && !out_free);
	assign go       = !stall;

	assign items.ready = (cw.act == A_FETCH);

	assign unsup = ({1'b0, ch_q} >= 9'(CHANNELS)) || ((ch_q != 8'd0) && !mux_q);

	assign cur_idx  = cur_q[IDX_W-1:0];
	assign cur_next = (cur_idx == LAST_IDX) ? '0 : cur_idx + 1'b1;
	assign x_next   = (x_q == LAST_IDX) ? '0 : x_q + 1'b1;

	// single read port into the pending bits
	always_comb begin
		case (cw.act)
			A_MUL:   rd_idx = cur_idx;
			A_SCAN:  rd_idx = x_q;
			default: rd_idx = ch_q[IDX_W-1:0];
		endcase
	end
	assign pend_rd = pend_q[rd_idx];

	assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 16'd1;

	assign scaled   = prod_q >> shift_q;
	// divide by sixteen, truncating toward zero
	assign div_val  = (diff_q + (diff_q[27] ? TRUNC_BIAS : 28'sd0)) >>> 4;
	assign meas_val = (code_q == 16'd0) ? OVERLOAD_UV : (range_q ? div_val : diff_q);

	always_comb begin
		unique case (cw.cond)
			C_NEXT:       jump = 1'b0;
			C_ALWAYS:     jump = 1'b1;
			C_OP_NOT_REQ: jump = (op_q != OP_REQ);
			C_UNSUP:      jump = unsup;
			C_NO_START:   jump = pend_rd || busy_q;
			C_OP3:        jump = (op_q == OP_NONE);
			C_OP_DONE:    jump = (op_q == OP_DONE);
			C_NO_TMO:     jump = !busy_q || (elapsed_inc < timeout_q);
			C_IDLE:       jump = !busy_q;
			C_NONE_PEND:  jump = (cnt_q == '0);
			C_NOT_HIT:    jump = !pend_rd;
			default:      jump = 1'b1;
		endcase
	end

	// sequencer and scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= S_FETCH;
			pend_q    <= '0;
			cnt_q     <= '0;
			busy_q    <= 1'b0;
			cur_q     <= 8'd0;
			elapsed_q <= 16'd0;
			x_q       <= '0;
			tmo_q     <= 1'b0;
		end else if (go) begin
			pc_q <= jump ? cw.target : pc_q + 4'd1;
			case (cw.act)
				A_SET_PEND: begin
					if (!pend_rd) begin
						pend_q[rd_idx] <= 1'b1;
						cnt_q          <= cnt_q + 1'b1;
					end
				end
				A_START_REQ: begin
					busy_q    <= 1'b1;
					cur_q     <= ch_q;
					elapsed_q <= 16'd0;
				end
				A_START_SCAN: begin
					busy_q    <= 1'b1;
					cur_q     <= 8'(x_q);
					elapsed_q <= 16'd0;
				end
				A_CLR_TMO: tmo_q <= 1'b0;
				A_TICK: begin
					if (busy_q) begin
						elapsed_q <= elapsed_inc;
					end
					tmo_q <= 1'b1;
				end
				A_MUL: begin
					// drop the finished channel
					busy_q <= 1'b0;
					if (pend_rd) begin
						pend_q[rd_idx] <= 1'b0;
						cnt_q          <= cnt_q - 1'b1;
					end
				end
				A_SCAN_INIT: x_q <= cur_next;
				A_SCAN: begin
					if (!pend_rd) begin
						x_q <= x_next;
					end
				end
				default: ;
			endcase
		end
	end

	// item latch and arithmetic
	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			op_q   <= items.opcode;
			ch_q   <= items.channel;
			code_q <= items.adc_code;
		end
		if (go && (cw.act == A_MUL)) begin
			prod_q <= 26'(code_q) * 26'(CODE_SCALE);
		end
		if (go && (cw.act == A_SUB)) begin
			diff_q <= VOLT_OFFSET - $signed({2'b00, scaled});
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (go && cw.emit) begin
			ov_q <= 1'b1;
		end else if (results.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && cw.emit) begin
			case (cw.act)
				A_RESULT: begin
					o_kind_q  <= KIND_RESULT;
					o_chan_q  <= cur_q;
					o_volts_q <= meas_val;
					o_ovl_q   <= (code_q == 16'd0);
					o_tmo_q   <= tmo_q;
					o_uns_q   <= 1'b0;
					o_cw_q    <= 4'd0;
					o_last_q  <= (cnt_q == '0);
				end
				A_UNSUP: begin
					o_kind_q  <= KIND_RESULT;
					o_chan_q  <= ch_q;
					o_volts_q <= 28'sd0;
					o_ovl_q   <= 1'b0;
					o_tmo_q   <= 1'b0;
					o_uns_q   <= 1'b1;
					o_cw_q    <= 4'd0;
					o_last_q  <= 1'b1;
				end
				default: begin
					o_kind_q  <= KIND_START;
					o_chan_q  <= (cw.act == A_START_SCAN) ? 8'(x_q) : ch_q;
					o_volts_q <= 28'sd0;
					o_ovl_q   <= 1'b0;
					o_tmo_q   <= 1'b0;
					o_uns_q   <= 1'b0;
					o_cw_q    <= {range_q, shift_q};
					o_last_q  <= 1'b1;
				end
			endcase
		end
	end

	assign results.valid        = ov_q;
	assign results.kind         = o_kind_q;
	assign results.chan_out     = o_chan_q;
	assign results.volts_value  = o_volts_q;
	assign results.overload     = o_ovl_q;
	assign results.timed_out    = o_tmo_q;
	assign results.unsupported  = o_uns_q;
	assign results.control_word = o_cw_q;
	assign results.last         = o_last_q;

	// register block
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mux_q     <= 1'b0;
			range_q   <= 1'b0;
			shift_q   <= SHIFT_RST;
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				R_MUX:     mux_q     <= pwdata[0];
				R_RANGE:   range_q   <= pwdata[0];
				R_SHIFT:   shift_q   <= pwdata[2:0];
				R_TIMEOUT: timeout_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			R_MUX:     prdata = {31'd0, mux_q};
			R_RANGE:   prdata = {31'd0, range_q};
			R_SHIFT:   prdata = {29'd0, shift_q};
			R_TIMEOUT: prdata = {16'd0, timeout_q};
			default:   prdata = 32'd0;
		endcase
	end

	// checks
	a_cnt_matches_bits: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == S_FETCH) |-> (cnt_q == CNT_W'($countones(pend_q))))
		else $error("pending count out of step with pending bits");

	a_busy_iff_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == S_FETCH) |-> (busy_q == (cnt_q != '0)))
		else $error("busy flag disagrees with pending count");

	a_cur_pending: assert property (@(posedge clk) disable iff (!arst_n)
		((pc_q == S_FETCH) && busy_q) |-> pend_q[cur_idx])
		else $error("running channel not marked pending");

	a_scan_has_target: assert property (@(posedge clk) disable iff (!arst_n)
		(cw.act == A_SCAN) |-> (cnt_q != '0))
		else $error("round-robin scan entered with nothing pending");

	a_emit_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(cw.emit && ov_q && !results.ready) |=> (pc_q == $past(pc_q)))
		else $error("sequencer moved past a blocked emit step");

endmodule
